// ----- sv/hbck_pkg.sv -----
// hbck_pkg: shared types, constants and the reciprocal table for the hue band color keep block
// no dependencies; used by every module of the block through scoped names
`timescale 1ns / 1ps
`default_nettype none

package hbck_pkg;

   // hue fixed point: degrees times 2^HUE_FRAC_BITS
   localparam int HUE_FRAC_BITS  = 6;
   localparam int HUE_SCALE      = 1 << HUE_FRAC_BITS;
   localparam int HUE_FULL       = 360 * HUE_SCALE;
   localparam int HUE_SECTOR     = 60 * HUE_SCALE;
   localparam int HUE_GREEN_BASE = 120 * HUE_SCALE;
   localparam int HUE_BLUE_BASE  = 240 * HUE_SCALE;
   localparam int HUE_W          = $clog2(HUE_FULL);
   localparam int QUOT_W         = $clog2(HUE_SECTOR + 1);

   // scaled numerator a * HUE_SECTOR with a up to 255
   localparam int NUM_W          = $clog2(255 * HUE_SECTOR + 1);

   // reciprocal of the component spread, floor(2^RECIP_SHIFT / d)
   localparam int RECIP_SHIFT    = NUM_W;
   localparam int RECIP_W        = RECIP_SHIFT + 1;
   localparam int PROD_W         = NUM_W + RECIP_W;

   // configuration field widths
   localparam int CENTER_W       = 15;
   localparam int HALF_W         = 14;
   localparam int WEIGHT_W       = 9;
   localparam int CSR_DATA_W     = 15;
   localparam int CSR_INDEX_W    = 3;

   localparam int LUMA_PROD_W    = WEIGHT_W + 8;
   localparam int LUMA_SUM_W     = LUMA_PROD_W + 2;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_HUE_CENTER    = 3'd0,
      REG_HUE_HALFWIDTH = 3'd1,
      REG_WEIGHT_RED    = 3'd2,
      REG_WEIGHT_GREEN  = 3'd3,
      REG_WEIGHT_BLUE   = 3'd4
   } csr_index_type;

   // hue sector chosen by the largest component
   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [CENTER_W-1:0] hue_center;
      logic [HALF_W-1:0]   hue_halfwidth;
      logic [WEIGHT_W-1:0] weight_red;
      logic [WEIGHT_W-1:0] weight_green;
      logic [WEIGHT_W-1:0] weight_blue;
   } cfg_type;

   // pixel word leaving the hue pipeline
   typedef struct packed {
      logic             valid;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [HUE_W-1:0] hue;
   } hue_word_type;

   typedef logic [RECIP_W-1:0] recip_tab_type [256];

   // shift-subtract long division, evaluated once at elaboration
   function automatic recip_tab_type build_recip();
      recip_tab_type        tab;
      logic [RECIP_W:0]     rem;
      logic [RECIP_W-1:0]   quo;
      for (int dv = 0; dv < 256; dv++) begin
         rem = '0;
         quo = '0;
         for (int i = RECIP_SHIFT; i >= 0; i--) begin
            rem = {rem[RECIP_W-1:0], (i == RECIP_SHIFT)};
            if (dv != 0 && rem >= (RECIP_W+1)'(dv)) begin
               rem    = rem - (RECIP_W+1)'(dv);
               quo[i] = 1'b1;
            end
         end
         tab[dv] = (dv == 0) ? '0 : quo;
      end
      return tab;
   endfunction

   localparam recip_tab_type RECIP_TABLE = build_recip();

endpackage

`default_nettype wire

// ----- sv/hbck_csr.sv -----
// hbck_csr: configuration registers of the hue band color keep block
// depends on hbck_pkg for field widths, register indexes and cfg_type
`timescale 1ns / 1ps
`default_nettype none

module hbck_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [hbck_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  wire logic [hbck_pkg::CSR_DATA_W-1:0]   wr_data,
   output hbck_pkg::cfg_type                      cfg
);

   hbck_pkg::cfg_type cfg_ff, cfg_in;

   // decode the write, out-of-range indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (hbck_pkg::csr_index_type'(wr_index))
            hbck_pkg::REG_HUE_CENTER:    cfg_in.hue_center    = wr_data[hbck_pkg::CENTER_W-1:0];
            hbck_pkg::REG_HUE_HALFWIDTH: cfg_in.hue_halfwidth = wr_data[hbck_pkg::HALF_W-1:0];
            hbck_pkg::REG_WEIGHT_RED:    cfg_in.weight_red    = wr_data[hbck_pkg::WEIGHT_W-1:0];
            hbck_pkg::REG_WEIGHT_GREEN:  cfg_in.weight_green  = wr_data[hbck_pkg::WEIGHT_W-1:0];
            hbck_pkg::REG_WEIGHT_BLUE:   cfg_in.weight_blue   = wr_data[hbck_pkg::WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_center    <= hbck_pkg::CENTER_W'(0);
         cfg_ff.hue_halfwidth <= hbck_pkg::HALF_W'(320);
         cfg_ff.weight_red    <= hbck_pkg::WEIGHT_W'(77);
         cfg_ff.weight_green  <= hbck_pkg::WEIGHT_W'(150);
         cfg_ff.weight_blue   <= hbck_pkg::WEIGHT_W'(29);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- sv/hbck_hue.sv -----
// hbck_hue: five-stage hue pipeline (input, spread, reciprocal multiply, correction, assemble)
// depends on hbck_pkg for the reciprocal table, hue constants and hue_word_type
`timescale 1ns / 1ps
`default_nettype none

module hbck_hue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [7:0]        in_red,
   input  wire logic [7:0]        in_green,
   input  wire logic [7:0]        in_blue,
   output hbck_pkg::hue_word_type out_word
);

   localparam int NW = hbck_pkg::NUM_W;
   localparam int QW = hbck_pkg::QUOT_W;
   localparam int HW = hbck_pkg::HUE_W;
   localparam int RS = hbck_pkg::RECIP_SHIFT;

   // stage 1: input word
   logic        v1_ff;
   logic [7:0]  r1_ff, g1_ff, b1_ff;

   // stage 2: spread, sector, numerator magnitude
   logic                 v2_ff, v2_in;
   logic [7:0]           r2_ff, g2_ff, b2_ff;
   logic [7:0]           d2_ff, d2_in;
   hbck_pkg::sector_type sec2_ff, sec2_in;
   logic                 neg2_ff, neg2_in;
   logic [7:0]           a2_ff, a2_in;
   logic                 gray2_ff, gray2_in;

   // stage 3: quotient estimate
   logic                 v3_ff;
   logic [7:0]           r3_ff, g3_ff, b3_ff;
   logic [7:0]           d3_ff;
   hbck_pkg::sector_type sec3_ff;
   logic                 neg3_ff, gray3_ff;
   logic [NW-1:0]        n3_ff, n3_in;
   logic [QW-1:0]        q3_ff, q3_in;

   // stage 4: exact quotient and remainder flag
   logic                 v4_ff;
   logic [7:0]           r4_ff, g4_ff, b4_ff;
   hbck_pkg::sector_type sec4_ff;
   logic                 neg4_ff, gray4_ff;
   logic [QW-1:0]        q4_ff, q4_in;
   logic                 rnz4_ff, rnz4_in;

   // stage 5: hue
   logic                 v5_ff;
   logic [7:0]           r5_ff, g5_ff, b5_ff;
   logic [HW-1:0]        hue5_ff, hue5_in;

   // spread and sector, ties go to red then green
   logic [7:0]       mx, mn;
   logic signed [8:0] ndiff;
   always_comb begin
      if (r1_ff >= g1_ff && r1_ff >= b1_ff) begin
         sec2_in = hbck_pkg::SEC_RED;
         mx      = r1_ff;
         ndiff   = $signed({1'b0, g1_ff}) - $signed({1'b0, b1_ff});
      end else if (g1_ff >= b1_ff) begin
         sec2_in = hbck_pkg::SEC_GREEN;
         mx      = g1_ff;
         ndiff   = $signed({1'b0, b1_ff}) - $signed({1'b0, r1_ff});
      end else begin
         sec2_in = hbck_pkg::SEC_BLUE;
         mx      = b1_ff;
         ndiff   = $signed({1'b0, r1_ff}) - $signed({1'b0, g1_ff});
      end
      mn = r1_ff;
      if (g1_ff < mn) mn = g1_ff;
      if (b1_ff < mn) mn = b1_ff;
      d2_in    = mx - mn;
      gray2_in = (mx == mn);
      neg2_in  = ndiff[8];
      a2_in    = neg2_in ? 8'(-ndiff) : ndiff[7:0];
      v2_in    = v1_ff;
   end

   // scaled numerator times reciprocal of the spread
   logic [NW-1:0]                    num_b;
   logic [hbck_pkg::RECIP_W-1:0]     recip_b;
   logic [hbck_pkg::PROD_W-1:0]      prod_b;
   always_comb begin
      num_b   = NW'(a2_ff) * NW'(hbck_pkg::HUE_SECTOR);
      recip_b = hbck_pkg::RECIP_TABLE[d2_ff];
      prod_b  = hbck_pkg::PROD_W'(num_b) * hbck_pkg::PROD_W'(recip_b);
      n3_in   = num_b;
      q3_in   = prod_b[RS+QW-1:RS];
   end

   // the estimate is low by at most one, fix with one compare
   logic [NW-1:0] qd_c, rem_c;
   logic          fix_c;
   always_comb begin
      qd_c    = NW'(q3_ff) * NW'(d3_ff);
      rem_c   = n3_ff - qd_c;
      fix_c   = (rem_c >= NW'(d3_ff));
      q4_in   = q3_ff + QW'(fix_c);
      rnz4_in = fix_c ? (rem_c != NW'(d3_ff)) : (rem_c != '0);
   end

   // sector base plus floor of the signed offset, red wraps below zero
   logic [QW-1:0] mag_d;
   logic [HW-1:0] base_d;
   always_comb begin
      mag_d = q4_ff + QW'(neg4_ff & rnz4_ff);
      unique case (sec4_ff)
         hbck_pkg::SEC_GREEN: base_d = HW'(hbck_pkg::HUE_GREEN_BASE);
         hbck_pkg::SEC_BLUE:  base_d = HW'(hbck_pkg::HUE_BLUE_BASE);
         default:             base_d = neg4_ff ? HW'(hbck_pkg::HUE_FULL) : '0;
      endcase
      if (gray4_ff) begin
         hue5_in = '0;
      end else if (neg4_ff) begin
         hue5_in = base_d - HW'(mag_d);
      end else begin
         hue5_in = base_d + HW'(mag_d);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v2_in;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         r1_ff    <= in_red;
         g1_ff    <= in_green;
         b1_ff    <= in_blue;
         r2_ff    <= r1_ff;
         g2_ff    <= g1_ff;
         b2_ff    <= b1_ff;
         d2_ff    <= d2_in;
         sec2_ff  <= sec2_in;
         neg2_ff  <= neg2_in;
         a2_ff    <= a2_in;
         gray2_ff <= gray2_in;
         r3_ff    <= r2_ff;
         g3_ff    <= g2_ff;
         b3_ff    <= b2_ff;
         d3_ff    <= d2_ff;
         sec3_ff  <= sec2_ff;
         neg3_ff  <= neg2_ff;
         gray3_ff <= gray2_ff;
         n3_ff    <= n3_in;
         q3_ff    <= q3_in;
         r4_ff    <= r3_ff;
         g4_ff    <= g3_ff;
         b4_ff    <= b3_ff;
         sec4_ff  <= sec3_ff;
         neg4_ff  <= neg3_ff;
         gray4_ff <= gray3_ff;
         q4_ff    <= q4_in;
         rnz4_ff  <= rnz4_in;
         r5_ff    <= r4_ff;
         g5_ff    <= g4_ff;
         b5_ff    <= b4_ff;
         hue5_ff  <= hue5_in;
      end
   end

   assign out_word.valid = v5_ff;
   assign out_word.red   = r5_ff;
   assign out_word.green = g5_ff;
   assign out_word.blue  = b5_ff;
   assign out_word.hue   = hue5_ff;

endmodule

`default_nettype wire

// ----- sv/hbck_luma.sv -----
// hbck_luma: weighted luma, registered products then sum, shift and saturate
// depends on hbck_pkg for weight and product widths
`timescale 1ns / 1ps
`default_nettype none

module hbck_luma (
   input  wire logic                           clock,
   input  wire logic                           enable,
   input  wire logic [7:0]                     in_red,
   input  wire logic [7:0]                     in_green,
   input  wire logic [7:0]                     in_blue,
   input  wire logic [hbck_pkg::WEIGHT_W-1:0]  weight_red,
   input  wire logic [hbck_pkg::WEIGHT_W-1:0]  weight_green,
   input  wire logic [hbck_pkg::WEIGHT_W-1:0]  weight_blue,
   output logic [7:0]                          luma
);

   localparam int PW = hbck_pkg::LUMA_PROD_W;
   localparam int SW = hbck_pkg::LUMA_SUM_W;

   logic [PW-1:0] pr_ff, pg_ff, pb_ff;

   // one product per component
   always_ff @(posedge clock) begin
      if (enable) begin
         pr_ff <= PW'(weight_red) * PW'(in_red);
         pg_ff <= PW'(weight_green) * PW'(in_green);
         pb_ff <= PW'(weight_blue) * PW'(in_blue);
      end
   end

   // sum, drop the fraction, clamp to 8 bits
   logic [SW-1:0] sum;
   always_comb begin
      sum  = SW'(pr_ff) + SW'(pg_ff) + SW'(pb_ff);
      luma = (sum[SW-1:16] != '0) ? 8'hFF : sum[15:8];
   end

endmodule

`default_nettype wire

// ----- sv/hue_band_color_keep.sv -----
// hue_band_color_keep: top level, band test, output register and channel handshakes
// depends on hbck_pkg, hbck_csr, hbck_hue and hbck_luma
//
// Usage: one RGB pixel word enters on req_* and one word leaves on rsp_* for
// every pixel. A word moves when its valid is high and its stall is low.
// Pixels whose hue lies within hue_center +/- hue_halfwidth (wrapping around
// the circle) leave unchanged with rsp_in_band set; all others leave as gray
// luma in all three components with rsp_in_band clear.
// The seven-stage pipeline advances as a whole and takes one pixel per clock
// unless the receiver stalls. When the receiver stalls with a word waiting,
// the whole pipeline holds and req_stall rises in the same cycle; nothing is
// dropped or repeated. Write configuration registers on csr_* (always ready)
// only while no pixel is in flight; the block does not enforce this. Reset is
// synchronous: it empties the pipeline and loads the register defaults
// (center 0, half-width 320, weights 77/150/29).
`timescale 1ns / 1ps
`default_nettype none

module hue_band_color_keep (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_red,
   input  wire logic [7:0]                        req_green,
   input  wire logic [7:0]                        req_blue,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_out_red,
   output logic [7:0]                             rsp_out_green,
   output logic [7:0]                             rsp_out_blue,
   output logic                                   rsp_in_band,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [hbck_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hbck_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int HW = hbck_pkg::HUE_W;

   hbck_pkg::cfg_type      cfg;
   hbck_pkg::hue_word_type hword;
   logic                   advance;
   logic [7:0]             luma;

   // pipeline moves unless a finished word is held by the receiver
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   hbck_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   hbck_hue u_hue (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .in_red   (req_red),
      .in_green (req_green),
      .in_blue  (req_blue),
      .out_word (hword)
   );

   hbck_luma u_luma (
      .clock        (clock),
      .enable       (advance),
      .in_red       (hword.red),
      .in_green     (hword.green),
      .in_blue      (hword.blue),
      .weight_red   (cfg.weight_red),
      .weight_green (cfg.weight_green),
      .weight_blue  (cfg.weight_blue),
      .luma         (luma)
   );

   // stage 6: hue offset from the band center on the circle
   logic          v6_ff;
   logic [7:0]    r6_ff, g6_ff, b6_ff;
   logic [HW-1:0] diff6_ff, diff6_in;
   logic [HW-1:0] center_mod;
   logic [HW:0]   diff_raw;
   always_comb begin
      center_mod = (cfg.hue_center >= hbck_pkg::CENTER_W'(hbck_pkg::HUE_FULL))
                   ? HW'(cfg.hue_center - hbck_pkg::CENTER_W'(hbck_pkg::HUE_FULL))
                   : HW'(cfg.hue_center);
      diff_raw   = {1'b0, hword.hue} - {1'b0, center_mod};
      diff6_in   = diff_raw[HW] ? (diff_raw[HW-1:0] + HW'(hbck_pkg::HUE_FULL))
                                : diff_raw[HW-1:0];
   end

   // stage 7: circular distance, band decision and output select
   logic [HW-1:0] alt_c, dist_c;
   logic          inb_c;
   always_comb begin
      alt_c  = HW'(hbck_pkg::HUE_FULL) - diff6_ff;
      dist_c = (alt_c < diff6_ff) ? alt_c : diff6_ff;
      inb_c  = (dist_c <= HW'(cfg.hue_halfwidth));
   end

   logic       rsp_valid_ff;
   logic [7:0] out_r_ff, out_g_ff, out_b_ff;
   logic       inb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v6_ff        <= hword.valid;
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r6_ff    <= hword.red;
         g6_ff    <= hword.green;
         b6_ff    <= hword.blue;
         diff6_ff <= diff6_in;
         out_r_ff <= inb_c ? r6_ff : luma;
         out_g_ff <= inb_c ? g6_ff : luma;
         out_b_ff <= inb_c ? b6_ff : luma;
         inb_ff   <= inb_c;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_in_band   = inb_ff;

endmodule

`default_nettype wire
